// ----- rtl/core/dual_pulse_peak_time_tracker_core_macros.svh -----
// Assertion macros used by the checker file of the peak time tracker.
`ifndef DUAL_PULSE_PEAK_TIME_TRACKER_CORE_MACROS_SVH
`define DUAL_PULSE_PEAK_TIME_TRACKER_CORE_MACROS_SVH

// General form: explicit clock and active-low reset.
`define DPPT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Short form for checkers that use the block's own clock and reset names.
`define DPPT_CHECK(lbl, prop, msg) `DPPT_ASSERT(lbl, i_clk, i_rst_n, prop, msg)

`endif

// ----- rtl/core/dppt_pkg.sv -----
`default_nettype none

package dppt_pkg;

    // Field widths.
    localparam int SAMPLE_W = 16;
    localparam int MAG_W    = 16;
    localparam int THR_W    = 15;
    localparam int TIME_W   = 32;
    localparam int FLIGHT_W = 33;
    localparam int PHASE_W  = 2;

    // Configuration port.
    localparam int APB_DATA_W = 32;
    localparam int ADDR_W     = 3;
    localparam int REG_IDX_W  = 1;
    localparam logic [REG_IDX_W-1:0] REG_ARM_THRESHOLD = 1'd0;
    localparam logic [THR_W-1:0]     ARM_THRESHOLD_RESET = 15'd164;

    // Phase codes as they appear on the result.
    localparam logic [PHASE_W-1:0] PHASE_CODE_WAIT  = 2'd0;
    localparam logic [PHASE_W-1:0] PHASE_CODE_TRACK = 2'd1;
    localparam logic [PHASE_W-1:0] PHASE_CODE_LOCK  = 2'd2;

    // Internal one-hot tracker state.
    typedef enum logic [2:0] {
        PH_WAIT  = 3'b001,
        PH_TRACK = 3'b010,
        PH_LOCK  = 3'b100
    } t_phase;

    // Status of one probe tracker.
    typedef struct packed {
        t_phase              phase;
        logic [MAG_W-1:0]    peak_mag;
        logic [TIME_W-1:0]   peak_time;
    } t_probe_state;

    // Map the one-hot state onto the result code.
    function automatic logic [PHASE_W-1:0] phase_code(input t_phase ph);
        logic [PHASE_W-1:0] code;
        case (ph)
            PH_TRACK: code = PHASE_CODE_TRACK;
            PH_LOCK:  code = PHASE_CODE_LOCK;
            default:  code = PHASE_CODE_WAIT;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/dppt_in_if.sv -----
`default_nettype none

// Input channel: one sample pair and its time stamp per transaction.
interface dppt_in_if import dppt_pkg::*;;
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample_a;
    logic signed [SAMPLE_W-1:0] sample_b;
    logic [TIME_W-1:0]          time_stamp;

    modport source (output valid, output sample_a, output sample_b, output time_stamp,
                    input ready);
    modport sink (input valid, input sample_a, input sample_b, input time_stamp,
                  output ready);
endinterface

`default_nettype wire

// ----- rtl/core/dppt_out_if.sv -----
`default_nettype none

// Result channel: tracker status of both probes per transaction.
interface dppt_out_if import dppt_pkg::*;;
    logic                       valid;
    logic                       ready;
    logic [PHASE_W-1:0]         phase_a_out;
    logic [PHASE_W-1:0]         phase_b_out;
    logic [MAG_W-1:0]           peak_mag_a_out;
    logic [MAG_W-1:0]           peak_mag_b_out;
    logic [TIME_W-1:0]          peak_time_a_out;
    logic [TIME_W-1:0]          peak_time_b_out;
    logic signed [FLIGHT_W-1:0] flight_time;
    logic                       both_locked;

    modport source (output valid, output phase_a_out, output phase_b_out,
                    output peak_mag_a_out, output peak_mag_b_out,
                    output peak_time_a_out, output peak_time_b_out,
                    output flight_time, output both_locked, input ready);
    modport sink (input valid, input phase_a_out, input phase_b_out,
                  input peak_mag_a_out, input peak_mag_b_out,
                  input peak_time_a_out, input peak_time_b_out,
                  input flight_time, input both_locked, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/dual_pulse_peak_time_tracker_core.sv -----
// An accepted input waits in the input register; its result is loaded when the
// input stage advances. Throughput: one sample pair per cycle while the output
// is not stalled; the two probe trackers update once per item in the stage
// between the input register and the result register.
// Reset (synchronous, active low) empties both stages, puts both probes in the
// waiting phase with zero peaks and times, and sets the arm threshold to 164.
`default_nettype none

module dual_pulse_peak_time_tracker_core import dppt_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    dppt_in_if.sink               i_in,
    dppt_out_if.source            o_out,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_W-1:0]     paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic                       r_s1_valid;
    logic signed [SAMPLE_W-1:0] r_s1_sample_a;
    logic signed [SAMPLE_W-1:0] r_s1_sample_b;
    logic [TIME_W-1:0]          r_s1_time;
    logic                       r_out_valid;
    logic [THR_W-1:0]           r_arm_threshold;
    logic                       s1_advance;
    logic                       cfg_write;
    logic                       sel_arm_threshold;
    t_probe_state               probe_a_state;
    t_probe_state               probe_b_state;

    // Register access.
    assign pready            = 1'b1;
    assign sel_arm_threshold = paddr[ADDR_W-1:2] == REG_ARM_THRESHOLD;
    assign cfg_write         = psel && penable && pwrite && pready;
    assign prdata = sel_arm_threshold ? APB_DATA_W'(r_arm_threshold) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_arm_threshold <= ARM_THRESHOLD_RESET;
        end else if (cfg_write && sel_arm_threshold) begin
            r_arm_threshold <= pwdata[THR_W-1:0];
        end
    end

    // Handshake: the input stage moves on whenever the result register is free.
    assign s1_advance = r_s1_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_s1_valid || s1_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_in.ready) begin
                r_s1_valid <= i_in.valid;
            end
            if (s1_advance) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Input register payload.
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_s1_sample_a <= i_in.sample_a;
            r_s1_sample_b <= i_in.sample_b;
            r_s1_time     <= i_in.time_stamp;
        end
    end

    // One tracker per probe; their state registers form the result payload.
    dppt_probe u_probe_a (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_advance   (s1_advance),
        .i_sample    (r_s1_sample_a),
        .i_time      (r_s1_time),
        .i_threshold (r_arm_threshold),
        .o_state     (probe_a_state)
    );

    dppt_probe u_probe_b (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_advance   (s1_advance),
        .i_sample    (r_s1_sample_b),
        .i_time      (r_s1_time),
        .i_threshold (r_arm_threshold),
        .o_state     (probe_b_state)
    );

    // Result transaction.
    assign o_out.valid           = r_out_valid;
    assign o_out.phase_a_out     = phase_code(probe_a_state.phase);
    assign o_out.phase_b_out     = phase_code(probe_b_state.phase);
    assign o_out.peak_mag_a_out  = probe_a_state.peak_mag;
    assign o_out.peak_mag_b_out  = probe_b_state.peak_mag;
    assign o_out.peak_time_a_out = probe_a_state.peak_time;
    assign o_out.peak_time_b_out = probe_b_state.peak_time;
    assign o_out.flight_time     = {1'b0, probe_b_state.peak_time}
                                 - {1'b0, probe_a_state.peak_time};
    assign o_out.both_locked     = (probe_a_state.phase == PH_LOCK)
                                && (probe_b_state.phase == PH_LOCK);

endmodule

`default_nettype wire

// ----- rtl/core/dppt_probe.sv -----
`default_nettype none

// Three-phase peak tracker for one probe. The state registers double as the
// result payload, since they only change when a new result is loaded.
module dppt_probe import dppt_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_advance,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    input  logic [TIME_W-1:0]          i_time,
    input  logic [THR_W-1:0]           i_threshold,
    output t_probe_state               o_state
);

    t_phase            r_phase, n_phase;
    logic [MAG_W-1:0]  r_peak_mag, n_peak_mag;
    logic [TIME_W-1:0] r_peak_time, n_peak_time;
    logic [MAG_W-1:0]  mag;
    logic              above_thr;
    logic              above_peak;
    logic              below_half;

    // Absolute value; the most negative sample gives exactly 32768.
    assign mag = i_sample[SAMPLE_W-1] ? MAG_W'(~i_sample + 1'b1) : MAG_W'(i_sample);

    assign above_thr  = mag > {1'b0, i_threshold};
    assign above_peak = mag > r_peak_mag;
    assign below_half = {mag, 1'b0} < {1'b0, r_peak_mag};

    // Next-state logic for the tracker.
    always_comb begin
        n_phase     = r_phase;
        n_peak_mag  = r_peak_mag;
        n_peak_time = r_peak_time;
        case (r_phase)
            PH_WAIT: begin
                if (above_thr) begin
                    n_phase     = PH_TRACK;
                    n_peak_mag  = mag;
                    n_peak_time = i_time;
                end
            end
            PH_TRACK: begin
                if (above_peak) begin
                    n_peak_mag  = mag;
                    n_peak_time = i_time;
                end else if (below_half) begin
                    n_phase = PH_LOCK;
                end
            end
            PH_LOCK: begin
                n_phase = PH_LOCK;
            end
            default: begin
                n_phase = PH_WAIT;
            end
        endcase
    end

    // State update, one step per item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_WAIT;
            r_peak_mag  <= '0;
            r_peak_time <= '0;
        end else if (i_advance) begin
            r_phase     <= n_phase;
            r_peak_mag  <= n_peak_mag;
            r_peak_time <= n_peak_time;
        end
    end

    assign o_state.phase     = r_phase;
    assign o_state.peak_mag  = r_peak_mag;
    assign o_state.peak_time = r_peak_time;

endmodule

`default_nettype wire

// ----- rtl/core/dppt_checker.sv -----
`default_nettype none

`include "dual_pulse_peak_time_tracker_core_macros.svh"

// Port-level checks on the tracker's handshake and result fields.
module dppt_checker import dppt_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic [PHASE_W-1:0] i_phase_a,
    input logic [PHASE_W-1:0] i_phase_b,
    input logic [MAG_W-1:0]   i_peak_mag_a,
    input logic               i_both_locked
);

    // A pending result stays offered until the consumer takes it.
    `DPPT_CHECK(a_out_valid_holds, i_out_valid && !i_out_ready |=> i_out_valid, "result dropped while stalled")

    // An empty result register never holds back the input side.
    `DPPT_CHECK(a_ready_when_empty, !i_out_valid |-> i_in_ready, "input stalled with empty output")

    // The lock flag matches both reported phases.
    `DPPT_CHECK(a_both_locked_match, i_out_valid |-> (i_both_locked == ((i_phase_a == PHASE_CODE_LOCK) && (i_phase_b == PHASE_CODE_LOCK))), "both_locked disagrees with phases")

    // A locked probe A stays locked until reset.
    `DPPT_CHECK(a_lock_sticky, i_out_valid && (i_phase_a == PHASE_CODE_LOCK) |=> !i_out_valid || (i_phase_a == PHASE_CODE_LOCK), "probe A left the locked phase")

    // Once armed, probe A always reports a nonzero peak.
    `DPPT_CHECK(a_peak_nonzero, i_out_valid && (i_phase_a != PHASE_CODE_WAIT) |-> i_peak_mag_a != '0, "armed probe A with zero peak")

endmodule

bind dual_pulse_peak_time_tracker_core dppt_checker u_dppt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_phase_a     (o_out.phase_a_out),
    .i_phase_b     (o_out.phase_b_out),
    .i_peak_mag_a  (o_out.peak_mag_a_out),
    .i_both_locked (o_out.both_locked)
);

`default_nettype wire
